[src/rvdec_pkg.sv]
`default_nettype none

package rvdec_pkg;

  // Major opcodes, instruction bits 6 to 0.
  localparam logic [6:0] OPC_MASK     = 7'h7F;
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_OP_32    = 7'h3B;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  // Upper-immediate mask and the two exact environment call words.
  localparam logic [31:0] U_MASK   = 32'hFFFF_F000;
  localparam logic [31:0] W_ECALL  = 32'h0000_0073;
  localparam logic [31:0] W_EBREAK = 32'h0010_0073;

  // Function field values that select the base or alternate operation.
  localparam logic [6:0] F7_BASE  = 7'h00;
  localparam logic [6:0] F7_ALT   = 7'h20;
  localparam logic [5:0] F6_BASE  = 6'h00;
  localparam logic [5:0] F6_ALT   = 6'h10;

  // Dense operation code, zero meaning an unrecognised word.
  typedef enum logic [5:0] {
    OP_UNKNOWN = 6'd0,
    OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
    OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
    OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU, OP_LWU,
    OP_SB, OP_SH, OP_SW, OP_SD,
    OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
    OP_SLLI, OP_SRLI, OP_SRAI,
    OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW,
    OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR,
    OP_SRL, OP_SRA, OP_OR, OP_AND,
    OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW,
    OP_FENCE, OP_FENCE_I, OP_ECALL, OP_EBREAK, OP_SYSTEM
  } op_kind_t;

endpackage : rvdec_pkg

`default_nettype wire

[src/rvdec_decode.sv]
`default_nettype none

module rvdec_decode
  import rvdec_pkg::*;
(
  input  wire logic [31:0] instr,
  output op_kind_t         op_kind,
  output logic [31:0]      immediate
);

  // Format immediates, each sign-extended from its top instruction bit.
  function automatic logic [31:0] imm_i(input logic [31:0] w);
    imm_i = {{20{w[31]}}, w[31:20]};
  endfunction

  function automatic logic [31:0] imm_s(input logic [31:0] w);
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  endfunction

  function automatic logic [31:0] imm_b(input logic [31:0] w);
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

  function automatic logic [31:0] imm_j(input logic [31:0] w);
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  endfunction

  // Per-funct3 operation tables of the regular opcode groups.
  function automatic op_kind_t branch_op(input logic [2:0] f3);
    case (f3)
      3'd0:    branch_op = OP_BEQ;
      3'd1:    branch_op = OP_BNE;
      3'd4:    branch_op = OP_BLT;
      3'd5:    branch_op = OP_BGE;
      3'd6:    branch_op = OP_BLTU;
      3'd7:    branch_op = OP_BGEU;
      default: branch_op = OP_UNKNOWN;
    endcase
  endfunction

  function automatic op_kind_t load_op(input logic [2:0] f3);
    case (f3)
      3'd0:    load_op = OP_LB;
      3'd1:    load_op = OP_LH;
      3'd2:    load_op = OP_LW;
      3'd3:    load_op = OP_LD;
      3'd4:    load_op = OP_LBU;
      3'd5:    load_op = OP_LHU;
      3'd6:    load_op = OP_LWU;
      default: load_op = OP_UNKNOWN;
    endcase
  endfunction

  function automatic op_kind_t store_op(input logic [2:0] f3);
    case (f3)
      3'd0:    store_op = OP_SB;
      3'd1:    store_op = OP_SH;
      3'd2:    store_op = OP_SW;
      3'd3:    store_op = OP_SD;
      default: store_op = OP_UNKNOWN;
    endcase
  endfunction

  function automatic op_kind_t alui_op(input logic [2:0] f3);
    case (f3)
      3'd0:    alui_op = OP_ADDI;
      3'd2:    alui_op = OP_SLTI;
      3'd3:    alui_op = OP_SLTIU;
      3'd4:    alui_op = OP_XORI;
      3'd6:    alui_op = OP_ORI;
      3'd7:    alui_op = OP_ANDI;
      default: alui_op = OP_UNKNOWN;
    endcase
  endfunction

  function automatic op_kind_t r_op(input logic [2:0] f3);
    case (f3)
      3'd0:    r_op = OP_ADD;
      3'd1:    r_op = OP_SLL;
      3'd2:    r_op = OP_SLT;
      3'd3:    r_op = OP_SLTU;
      3'd4:    r_op = OP_XOR;
      3'd5:    r_op = OP_SRL;
      3'd6:    r_op = OP_OR;
      default: r_op = OP_AND;
    endcase
  endfunction

  logic [6:0] opcode;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] f6;
  logic [31:0] shamt6;
  logic [31:0] shamt5;

  assign opcode = instr[6:0] & OPC_MASK;
  assign f3     = instr[14:12];
  assign f7     = instr[31:25];
  assign f6     = instr[31:26];
  assign shamt6 = {26'd0, instr[25:20]};
  assign shamt5 = {27'd0, instr[24:20]};

  // Opcode group decode. The immediate stays zero unless a known operation
  // of a format that carries one is matched.
  always_comb begin
    op_kind   = OP_UNKNOWN;
    immediate = '0;
    case (opcode)
      OPC_LUI: begin
        op_kind   = OP_LUI;
        immediate = instr & U_MASK;
      end
      OPC_AUIPC: begin
        op_kind   = OP_AUIPC;
        immediate = instr & U_MASK;
      end
      OPC_JAL: begin
        op_kind   = OP_JAL;
        immediate = imm_j(instr);
      end
      OPC_JALR: begin
        if (f3 == 3'd0) begin
          op_kind   = OP_JALR;
          immediate = imm_i(instr);
        end
      end
      OPC_BRANCH: begin
        op_kind = branch_op(f3);
        if (op_kind != OP_UNKNOWN) immediate = imm_b(instr);
      end
      OPC_LOAD: begin
        op_kind = load_op(f3);
        if (op_kind != OP_UNKNOWN) immediate = imm_i(instr);
      end
      OPC_STORE: begin
        op_kind = store_op(f3);
        if (op_kind != OP_UNKNOWN) immediate = imm_s(instr);
      end
      OPC_OP_IMM: begin
        // 64-bit shifts check funct6 and give a six-bit shift amount.
        if (f3 == 3'd1) begin
          if (f6 == F6_BASE) begin
            op_kind   = OP_SLLI;
            immediate = shamt6;
          end
        end else if (f3 == 3'd5) begin
          if (f6 == F6_BASE) begin
            op_kind   = OP_SRLI;
            immediate = shamt6;
          end else if (f6 == F6_ALT) begin
            op_kind   = OP_SRAI;
            immediate = shamt6;
          end
        end else begin
          op_kind = alui_op(f3);
          if (op_kind != OP_UNKNOWN) immediate = imm_i(instr);
        end
      end
      OPC_OP_IMM32: begin
        // Word shifts check funct7 and give a five-bit shift amount.
        if (f3 == 3'd0) begin
          op_kind   = OP_ADDIW;
          immediate = imm_i(instr);
        end else if (f3 == 3'd1) begin
          if (f7 == F7_BASE) begin
            op_kind   = OP_SLLIW;
            immediate = shamt5;
          end
        end else if (f3 == 3'd5) begin
          if (f7 == F7_BASE) begin
            op_kind   = OP_SRLIW;
            immediate = shamt5;
          end else if (f7 == F7_ALT) begin
            op_kind   = OP_SRAIW;
            immediate = shamt5;
          end
        end
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          op_kind = r_op(f3);
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) op_kind = OP_SUB;
          else if (f3 == 3'd5) op_kind = OP_SRA;
        end
      end
      OPC_OP_32: begin
        if (f7 == F7_BASE) begin
          if (f3 == 3'd0) op_kind = OP_ADDW;
          else if (f3 == 3'd1) op_kind = OP_SLLW;
          else if (f3 == 3'd5) op_kind = OP_SRLW;
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) op_kind = OP_SUBW;
          else if (f3 == 3'd5) op_kind = OP_SRAW;
        end
      end
      OPC_MISC_MEM: begin
        if (f3 == 3'd0) op_kind = OP_FENCE;
        else if (f3 == 3'd1) op_kind = OP_FENCE_I;
      end
      OPC_SYSTEM: begin
        // Exact words first, then any other word with funct3 of zero.
        if (instr == W_ECALL) op_kind = OP_ECALL;
        else if (instr == W_EBREAK) op_kind = OP_EBREAK;
        else if (f3 == 3'd0) op_kind = OP_SYSTEM;
      end
      default: begin
        op_kind = OP_UNKNOWN;
      end
    endcase
  end

endmodule : rvdec_decode

`default_nettype wire

[src/rv64i_instruction_decoder_core.sv]
// RV64I instruction decoder. A transaction is taken on every clock edge at
// which start is high; busy is never raised, so one instruction word can be
// accepted in every cycle. Each word yields exactly one result, shown on the
// out_ ports for a single cycle with out_valid high, once the word has passed
// through the input register, the decode logic and the result register. The
// receiver cannot stall the block and must take every result in the cycle it
// appears.
`default_nettype none

module rv64i_instruction_decoder_core
  import rvdec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_instr,
  output logic             out_valid,
  output logic [5:0]       out_op_kind,
  output logic [4:0]       out_dest_reg,
  output logic [4:0]       out_src_reg_a,
  output logic [4:0]       out_src_reg_b,
  output logic signed [31:0] out_immediate
);

  logic        in_valid_r;
  logic        in_valid_nxt;
  logic [31:0] in_instr_r;
  logic        out_valid_r;
  logic [5:0]  op_kind_r;
  logic [4:0]  dest_reg_r;
  logic [4:0]  src_reg_a_r;
  logic [4:0]  src_reg_b_r;
  logic [31:0] immediate_r;
  op_kind_t    dec_op_kind;
  logic [31:0] dec_immediate;

  // The pipeline never holds off a new transaction.
  assign busy         = 1'b0;
  assign in_valid_nxt = start & ~busy;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
    if (in_valid_nxt) begin
      in_instr_r <= in_instr;
    end
  end

  // Decode logic between the two register stages.
  rvdec_decode u_decode (
    .instr     (in_instr_r),
    .op_kind   (dec_op_kind),
    .immediate (dec_immediate)
  );

  // Result register; the register fields are raw instruction bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
    if (in_valid_r) begin
      op_kind_r   <= dec_op_kind;
      dest_reg_r  <= in_instr_r[11:7];
      src_reg_a_r <= in_instr_r[19:15];
      src_reg_b_r <= in_instr_r[24:20];
      immediate_r <= dec_immediate;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_op_kind   = op_kind_r;
  assign out_dest_reg  = dest_reg_r;
  assign out_src_reg_a = src_reg_a_r;
  assign out_src_reg_b = src_reg_b_r;
  assign out_immediate = immediate_r;

endmodule : rv64i_instruction_decoder_core

`default_nettype wire

[src/rvdec_checker.sv]
`default_nettype none

module rvdec_checker
  import rvdec_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [31:0] in_instr,
  input wire logic        out_valid,
  input wire logic [5:0]  out_op_kind,
  input wire logic [4:0]  out_dest_reg,
  input wire logic [4:0]  out_src_reg_a,
  input wire logic [4:0]  out_src_reg_b,
  input wire logic signed [31:0] out_immediate
);

  // Every accepted transaction produces a result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) ##1 rst_n |=> out_valid)
    else $error("accepted instruction produced no result");

  // No result appears without an earlier accepted transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted instruction");

  // Register fields are the raw bits of the matching instruction word.
  a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dest_reg == $past(in_instr[11:7], 2))
               && (out_src_reg_a == $past(in_instr[19:15], 2))
               && (out_src_reg_b == $past(in_instr[24:20], 2)))
    else $error("register fields do not match the instruction");

  // An unrecognised word carries no immediate.
  a_unknown_imm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_op_kind == OP_UNKNOWN) |-> out_immediate == 32'sd0)
    else $error("unknown instruction with a nonzero immediate");

  // Shift-immediate operations give only a shift amount.
  a_shamt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_op_kind == OP_SLLI || out_op_kind == OP_SRLI
                   || out_op_kind == OP_SRAI || out_op_kind == OP_SLLIW
                   || out_op_kind == OP_SRLIW || out_op_kind == OP_SRAIW))
    |-> out_immediate[31:6] == 26'd0)
    else $error("shift amount out of range");

endmodule : rvdec_checker

bind rv64i_instruction_decoder_core rvdec_checker u_rvdec_checker (.*);

`default_nettype wire

[bench/rv64i_decode_checker.sv]
module rv64i_decode_checker
  import rvdec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [31:0]        in_instr,
  input  logic               out_valid,
  input  logic [5:0]         out_op_kind,
  input  logic [4:0]         out_dest_reg,
  input  logic [4:0]         out_src_reg_a,
  input  logic [4:0]         out_src_reg_b,
  input  logic signed [31:0] out_immediate,
  output int                 mismatch_count,
  output int                 pending_count,
  output int                 decoded_count,
  output int                 kinds_seen
);

  // One decoded instruction word as the block should present it.
  typedef struct {
    logic [31:0] word;
    op_kind_t    kind;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } decoded_t;

  decoded_t    expected_decodes[$];
  int          errors  = 0;
  int          checked = 0;
  logic [54:0] kinds_hit = '0;

  // Decodes one word: operation, raw register fields and format immediate.
  function automatic decoded_t decode_word(input logic [31:0] w);
    decoded_t    d;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [31:0] imm_i;
    f3    = w[14:12];
    f7    = w[31:25];
    f6    = w[31:26];
    imm_i = {{20{w[31]}}, w[31:20]};
    d.word = w;
    d.kind = OP_UNKNOWN;
    d.rd   = w[11:7];
    d.rs1  = w[19:15];
    d.rs2  = w[24:20];
    d.imm  = '0;
    case (w[6:0])
      OPC_LUI: begin
        d.kind = OP_LUI;
        d.imm  = w & U_MASK;
      end
      OPC_AUIPC: begin
        d.kind = OP_AUIPC;
        d.imm  = w & U_MASK;
      end
      OPC_JAL: begin
        d.kind = OP_JAL;
        d.imm  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_JALR: begin
        if (f3 == 3'd0) begin
          d.kind = OP_JALR;
          d.imm  = imm_i;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          3'd0: d.kind = OP_BEQ;
          3'd1: d.kind = OP_BNE;
          3'd4: d.kind = OP_BLT;
          3'd5: d.kind = OP_BGE;
          3'd6: d.kind = OP_BLTU;
          3'd7: d.kind = OP_BGEU;
          default: ;
        endcase
        if (d.kind != OP_UNKNOWN)
          d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      end
      OPC_LOAD: begin
        case (f3)
          3'd0: d.kind = OP_LB;
          3'd1: d.kind = OP_LH;
          3'd2: d.kind = OP_LW;
          3'd3: d.kind = OP_LD;
          3'd4: d.kind = OP_LBU;
          3'd5: d.kind = OP_LHU;
          3'd6: d.kind = OP_LWU;
          default: ;
        endcase
        if (d.kind != OP_UNKNOWN) d.imm = imm_i;
      end
      OPC_STORE: begin
        case (f3)
          3'd0: d.kind = OP_SB;
          3'd1: d.kind = OP_SH;
          3'd2: d.kind = OP_SW;
          3'd3: d.kind = OP_SD;
          default: ;
        endcase
        if (d.kind != OP_UNKNOWN) d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      OPC_OP_IMM: begin
        case (f3)
          3'd0: d.kind = OP_ADDI;
          3'd1: if (f6 == F6_BASE) d.kind = OP_SLLI;
          3'd2: d.kind = OP_SLTI;
          3'd3: d.kind = OP_SLTIU;
          3'd4: d.kind = OP_XORI;
          3'd5: begin
            if (f6 == F6_BASE) d.kind = OP_SRLI;
            else if (f6 == F6_ALT) d.kind = OP_SRAI;
          end
          3'd6: d.kind = OP_ORI;
          default: d.kind = OP_ANDI;
        endcase
        // Shifts carry a six-bit amount rather than the I immediate.
        if (d.kind != OP_UNKNOWN)
          d.imm = (f3 == 3'd1 || f3 == 3'd5) ? {26'd0, w[25:20]} : imm_i;
      end
      OPC_OP_IMM32: begin
        case (f3)
          3'd0: d.kind = OP_ADDIW;
          3'd1: if (f7 == F7_BASE) d.kind = OP_SLLIW;
          3'd5: begin
            if (f7 == F7_BASE) d.kind = OP_SRLIW;
            else if (f7 == F7_ALT) d.kind = OP_SRAIW;
          end
          default: ;
        endcase
        if (d.kind != OP_UNKNOWN)
          d.imm = (f3 == 3'd0) ? imm_i : {27'd0, w[24:20]};
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: d.kind = OP_ADD;
            3'd1: d.kind = OP_SLL;
            3'd2: d.kind = OP_SLT;
            3'd3: d.kind = OP_SLTU;
            3'd4: d.kind = OP_XOR;
            3'd5: d.kind = OP_SRL;
            3'd6: d.kind = OP_OR;
            default: d.kind = OP_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) d.kind = OP_SUB;
          else if (f3 == 3'd5) d.kind = OP_SRA;
        end
      end
      OPC_OP_32: begin
        if (f7 == F7_BASE) begin
          if (f3 == 3'd0) d.kind = OP_ADDW;
          else if (f3 == 3'd1) d.kind = OP_SLLW;
          else if (f3 == 3'd5) d.kind = OP_SRLW;
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) d.kind = OP_SUBW;
          else if (f3 == 3'd5) d.kind = OP_SRAW;
        end
      end
      OPC_MISC_MEM: begin
        if (f3 == 3'd0) d.kind = OP_FENCE;
        else if (f3 == 3'd1) d.kind = OP_FENCE_I;
      end
      OPC_SYSTEM: begin
        // Only the exact words are environment calls; other zero-funct3 words
        // fall into the generic system group.
        if (w == W_ECALL) d.kind = OP_ECALL;
        else if (w == W_EBREAK) d.kind = OP_EBREAK;
        else if (f3 == 3'd0) d.kind = OP_SYSTEM;
      end
      default: ;
    endcase
    return d;
  endfunction

  // Prints one line per discrepancy and counts every one.
  task automatic report_mismatch(input string msg);
    errors++;
    $display("Error: %s", msg);
  endtask

  task automatic check_field(input string field, input decoded_t want,
                             input logic [31:0] got, input logic [31:0] exp);
    if (got !== exp)
      report_mismatch($sformatf("word %08h (%s): %s is %0h, expected %0h",
                                want.word, want.kind.name(), field, got, exp));
  endtask

  // Records each accepted transaction and compares each result strobe
  // against the oldest outstanding decode.
  always @(posedge clk) begin : watch
    decoded_t want;
    if (rst_n) begin
      if (start && !busy) expected_decodes.push_back(decode_word(in_instr));
      if (out_valid === 1'b1) begin
        if (expected_decodes.size() == 0) begin
          report_mismatch($sformatf("result with op %0d and no instruction outstanding",
                                    out_op_kind));
        end else begin
          want = expected_decodes.pop_front();
          check_field("op_kind", want, 32'(out_op_kind), 32'(want.kind));
          check_field("dest_reg", want, 32'(out_dest_reg), 32'(want.rd));
          check_field("src_reg_a", want, 32'(out_src_reg_a), 32'(want.rs1));
          check_field("src_reg_b", want, 32'(out_src_reg_b), 32'(want.rs2));
          check_field("immediate", want, out_immediate, want.imm);
          checked++;
          kinds_hit[want.kind] = 1'b1;
        end
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_decodes.size();
    decoded_count  <= checked;
    kinds_seen     <= $countones(kinds_hit);
  end

endmodule

[bench/tb_rv64i_instruction_decoder_core.sv]
module tb_rv64i_instruction_decoder_core;
  import rvdec_pkg::*;

  localparam int RANDOM_WORDS = 1248;
  localparam int PHASE_COUNT  = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [31:0]        in_instr;
  logic               out_valid;
  logic [5:0]         out_op_kind;
  logic [4:0]         out_dest_reg;
  logic [4:0]         out_src_reg_a;
  logic [4:0]         out_src_reg_b;
  logic signed [31:0] out_immediate;
  int                 mismatch_count;
  int                 pending_count;
  int                 decoded_count;
  int                 kinds_seen;
  int                 cycle_count = 0;

  // Field extremes, words that some decode paths reject, and the
  // exact-match system words.
  logic [31:0] directed_words [26] = '{
    32'h0000_0000, 32'hFFFF_FFFF, W_ECALL, W_EBREAK,
    32'h1020_0073, 32'h3000_1073, 32'hFFFF_F0B7, 32'h8000_006F,
    32'h8000_0067, 32'h0000_1067, 32'h8000_0F63, 32'h0000_7003,
    32'hFFF0_6003, 32'hFE00_3FA3, 32'h0000_4023, 32'h03F0_9093,
    32'h43F0_D093, 32'h8000_9093, 32'h0200_909B, 32'h41F0_D09B,
    32'hFFF0_009B, 32'h4000_0033, 32'h0200_0033, 32'h4000_503B,
    32'h0000_000F, 32'h0000_100F
  };

  rv64i_instruction_decoder_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_instr      (in_instr),
    .out_valid     (out_valid),
    .out_op_kind   (out_op_kind),
    .out_dest_reg  (out_dest_reg),
    .out_src_reg_a (out_src_reg_a),
    .out_src_reg_b (out_src_reg_b),
    .out_immediate (out_immediate)
  );

  rv64i_decode_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_instr       (in_instr),
    .out_valid      (out_valid),
    .out_op_kind    (out_op_kind),
    .out_dest_reg   (out_dest_reg),
    .out_src_reg_a  (out_src_reg_a),
    .out_src_reg_b  (out_src_reg_b),
    .out_immediate  (out_immediate),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .decoded_count  (decoded_count),
    .kinds_seen     (kinds_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guards against a hung handshake or results that never arrive.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding", pending_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Builds a word that is mostly well formed: a real major opcode, with
  // function fields steered towards the values that select an operation.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          sel;
    w = $urandom();
    if ($urandom_range(9) == 0) return w;
    case ($urandom_range(12))
      0:  w[6:0] = OPC_LUI;
      1:  w[6:0] = OPC_AUIPC;
      2:  w[6:0] = OPC_JAL;
      3:  w[6:0] = OPC_JALR;
      4:  w[6:0] = OPC_BRANCH;
      5:  w[6:0] = OPC_LOAD;
      6:  w[6:0] = OPC_STORE;
      7:  w[6:0] = OPC_OP_IMM;
      8:  w[6:0] = OPC_OP_IMM32;
      9:  w[6:0] = OPC_OP;
      10: w[6:0] = OPC_OP_32;
      11: w[6:0] = OPC_MISC_MEM;
      default: w[6:0] = OPC_SYSTEM;
    endcase
    sel = $urandom_range(9);
    case (w[6:0])
      OPC_OP_IMM: begin
        // Only the shift encodings look at funct6.
        if (w[13:12] == 2'b01) begin
          if (sel < 4) w[31:26] = F6_BASE;
          else if (sel < 8) w[31:26] = F6_ALT;
        end
      end
      OPC_OP_IMM32, OPC_OP, OPC_OP_32: begin
        if (sel < 4) w[31:25] = F7_BASE;
        else if (sel < 8) w[31:25] = F7_ALT;
      end
      OPC_SYSTEM: begin
        if (sel < 3) w = W_ECALL;
        else if (sel < 6) w = W_EBREAK;
        else if (sel < 8) w[14:12] = 3'd0;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Presents one word and holds it until the block takes the transaction.
  task automatic issue(input logic [31:0] w);
    start    <= 1'b1;
    in_instr <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Leaves the input idle for a random number of cycles, with junk on the
  // data port so that a word without start is seen to be ignored.
  task automatic idle_gap(input int percent);
    while ($urandom_range(99) < percent) begin
      start    <= 1'b0;
      in_instr <= $urandom();
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int percent;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_instr = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_words[i]) issue(directed_words[i]);

    // Phases: back to back, sparse input, back to back again (the result
    // side cannot stall, so its phase adds no gaps), then light gaps.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        1:       percent = 71;
        3:       percent = 19;
        default: percent = 0;
      endcase
      for (int n = 0; n < RANDOM_WORDS / PHASE_COUNT; n++) begin
        idle_gap(percent);
        issue(random_word());
      end
    end
    start <= 1'b0;

    // Let the checker see the last transaction, then drain the pipeline.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d decoded words: %0d directed, the rest random over four input phases.",
             decoded_count, $size(directed_words));
    $display("%0d of the 55 operation codes, unknown included, were produced.", kinds_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
